// ===== rtl/deq_pkg.sv =====
`default_nettype none
package deq_pkg;

	// default depth of the circular slot buffer
	localparam int CAPACITY_DEF = 16;

	// field widths
	localparam int CMD_W     = 3;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;
	localparam int M_TDATA_W = 104;

	// command codes (anything else is a status query)
	localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 3'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic capture;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop_ok;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       tuser: cmd[2:0]; tdata: push_value[31:0]
// m_       out        m_tvalid / m_tready       tuser: status[1:0]; tdata: popped_value,
//                                               entry_count, left_value, right_value, is_empty
//
// A push, query or failed pop passes EXEC then DONE; a successful pop has READ between them:
// the slot store has one registered read port, used once to refetch the new end word.
// One command is in work at a time; the next is taken while a result waits on m_.
// Reset (arst_n low) empties the queue; slot contents are not cleared.
// A stalled m_ side holds the result and blocks the next command at its result stage.
`default_nettype none
module double_ended_queue #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// push_value[31:0]
	input  wire logic [deq_pkg::DATA_W-1:0]    s_tdata,
	// cmd[2:0]
	input  wire logic [deq_pkg::CMD_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// popped_value[31:0], entry_count[36:32], left_value[68:37],
	// right_value[100:69], is_empty[101], zero[103:102]
	output logic      [deq_pkg::M_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic      [deq_pkg::STATUS_W-1:0]  m_tuser
);
	import deq_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	deq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/deq_ram.sv =====
`default_nettype none
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
`default_nettype none
module deq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire deq_pkg::dp_stat_t stat,
	output deq_pkg::ctrl_cmd_t     ctl
);
	import deq_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = stat.pop_ok ? S_READ : S_DONE;
			end
			S_READ: begin
				// refill the end cache from the slot behind the popped one
				ctl.capture = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/deq_dp.sv =====
`default_nettype none
module deq_dp #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire deq_pkg::ctrl_cmd_t              ctl,
	output deq_pkg::dp_stat_t                    stat,
	input  wire logic [deq_pkg::DATA_W-1:0]      s_tdata,
	input  wire logic [deq_pkg::CMD_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [deq_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic      [deq_pkg::STATUS_W-1:0]    m_tuser
);
	import deq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam int PAD_W = M_TDATA_W - (3 * DATA_W + COUNT_W + 1);

	// command register
	logic [CMD_W-1:0]    cmd_q;
	logic [DATA_W-1:0]   word_q;

	// queue state and cached end words
	logic [IW-1:0]       left_idx_q;
	logic [CW-1:0]       count_q;
	logic [DATA_W-1:0]   left_val_q;
	logic [DATA_W-1:0]   right_val_q;

	// per-command result
	logic [DATA_W-1:0]   popped_q;
	logic [STATUS_W-1:0] status_q;

	// output register
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [STATUS_W-1:0] out_user_q;

	logic                is_push;
	logic                is_pop;
	logic                full;
	logic                empty;
	logic                push_ok;
	logic                pop_ok;
	logic [IW-1:0]       left_dec;
	logic [IW-1:0]       left_inc;
	logic [SW-1:0]       sum_tail;
	logic [IW-1:0]       tail_idx;
	logic [CW-1:0]       count_dec;
	logic [SW-1:0]       sum_rr;
	logic [IW-1:0]       rr_idx;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic                ram_re;
	logic [IW-1:0]       ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;
	logic [CW+COUNT_W-1:0] cnt_ext;
	logic                out_empty;

	// command decode and occupancy
	always_comb begin
		is_push = (cmd_q == CMD_PUSH_LEFT) || (cmd_q == CMD_PUSH_RIGHT);
		is_pop  = (cmd_q == CMD_POP_LEFT) || (cmd_q == CMD_POP_RIGHT);
		full    = (count_q == CW'(CAPACITY));
		empty   = (count_q == '0);
		push_ok = is_push && !full;
		pop_ok  = is_pop && !empty;
	end

	// circular index arithmetic, one compare-subtract each
	always_comb begin
		left_dec  = (left_idx_q == '0) ? IW'(CAPACITY - 1) : left_idx_q - 1'b1;
		left_inc  = (left_idx_q == IW'(CAPACITY - 1)) ? '0 : left_idx_q + 1'b1;
		sum_tail  = SW'(left_idx_q) + SW'(count_q);
		tail_idx  = (sum_tail >= SW'(CAPACITY)) ? IW'(sum_tail - SW'(CAPACITY))
			: IW'(sum_tail);
		count_dec = count_q - 1'b1;
		// right end after a right pop; only used when entries remain
		sum_rr    = SW'(left_idx_q) + SW'(count_dec) - SW'(1);
		rr_idx    = (sum_rr >= SW'(CAPACITY)) ? IW'(sum_rr - SW'(CAPACITY))
			: IW'(sum_rr);
	end

	// slot store access
	always_comb begin
		ram_we    = ctl.exec && push_ok;
		ram_waddr = (cmd_q == CMD_PUSH_LEFT) ? left_dec : tail_idx;
		ram_re    = ctl.exec && pop_ok;
		ram_raddr = (cmd_q == CMD_POP_LEFT) ? left_inc : rr_idx;
	end

	deq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (word_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_idx_q <= '0;
			count_q    <= '0;
		end else if (ctl.exec) begin
			if (push_ok) begin
				count_q <= count_q + 1'b1;
				if (cmd_q == CMD_PUSH_LEFT) begin
					left_idx_q <= left_dec;
				end
			end else if (pop_ok) begin
				count_q <= count_dec;
				if (cmd_q == CMD_POP_LEFT) begin
					left_idx_q <= left_inc;
				end
			end
		end
	end

	// command capture, end caches, result
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= s_tuser;
			word_q <= s_tdata;
		end
		if (ctl.exec) begin
			popped_q <= '0;
			status_q <= ST_OK;
			if (is_push) begin
				if (full) begin
					status_q <= ST_OVERFLOW;
				end else if (cmd_q == CMD_PUSH_LEFT) begin
					left_val_q <= word_q;
					if (empty) begin
						right_val_q <= word_q;
					end
				end else begin
					right_val_q <= word_q;
					if (empty) begin
						left_val_q <= word_q;
					end
				end
			end else if (is_pop) begin
				if (empty) begin
					status_q <= ST_UNDERFLOW;
				end else begin
					popped_q <= (cmd_q == CMD_POP_LEFT) ? left_val_q : right_val_q;
				end
			end
		end
		if (ctl.capture && (count_q != '0)) begin
			if (cmd_q == CMD_POP_LEFT) begin
				left_val_q <= ram_rdata;
			end else begin
				right_val_q <= ram_rdata;
			end
		end
	end

	// output packing
	always_comb begin
		cnt_ext   = {{COUNT_W{1'b0}}, count_q};
		out_empty = (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_user_q <= status_q;
			out_data_q <= {
				{PAD_W{1'b0}},
				out_empty,
				out_empty ? {DATA_W{1'b0}} : right_val_q,
				out_empty ? {DATA_W{1'b0}} : left_val_q,
				cnt_ext[COUNT_W-1:0],
				popped_q
			};
		end
	end

	assign stat.pop_ok   = pop_ok;
	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign m_tuser       = out_user_q;

endmodule
`default_nettype wire

// ===== rtl/deq_chk.sv =====
`default_nettype none
module deq_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [deq_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [deq_pkg::STATUS_W-1:0]  m_tuser
);
	import deq_pkg::*;

	logic        res_empty;
	logic [31:0] res_popped;
	logic [31:0] res_left;
	logic [31:0] res_right;

	assign res_empty  = m_tdata[101];
	assign res_popped = m_tdata[31:0];
	assign res_left   = m_tdata[68:37];
	assign res_right  = m_tdata[100:69];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// empty queue shows zero at both ends
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_empty |-> res_left == '0 && res_right == '0)
		else $error("empty queue with nonzero end word");

	// underflow leaves an empty queue and no popped word
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_UNDERFLOW |-> res_empty && res_popped == '0)
		else $error("underflow on a non-empty queue");

	// overflow only on a nonempty queue, nothing popped
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OVERFLOW |-> !res_empty && res_popped == '0)
		else $error("overflow on an empty queue");

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);
`default_nettype wire
